[rtl/core/pjb_pkg.sv]
// packet jitter buffer package: widths, codes, state type and divider interface structs
// no dependencies; used by pjb_div and packet_jitter_buffer_core

package pjb_pkg;

  localparam int DEPTH  = 1024;
  localparam int SLOT_W = $clog2(DEPTH);
  localparam int CNT_W  = SLOT_W + 1;
  localparam int SESS_W = 64;
  localparam int OFF_W  = 64;
  localparam int LEN_W  = 16;
  localparam int HND_W  = 32;
  localparam int BB_W   = 25;
  localparam int THR_W  = LEN_W + CNT_W + 2;
  localparam int DIV_STEPS = OFF_W;
  localparam int DSTEP_W   = $clog2(DIV_STEPS);

  localparam logic [BB_W-1:0] BB_RESET = BB_W'(8 * 65536);

  localparam logic CMD_PACKET = 1'b0;
  localparam logic CMD_PULL   = 1'b1;

  typedef enum logic [2:0] {
    ST_FIRST   = 3'd0,
    ST_STORED  = 3'd1,
    ST_IGNORED = 3'd2,
    ST_RESTART = 3'd3,
    ST_PLAYED  = 3'd4,
    ST_NONE    = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_FDIV,
    S_FTHR,
    S_QDIV,
    S_MDIV,
    S_CHECK,
    S_PRD,
    S_PCHK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic             start;
    logic [OFF_W-1:0] dividend;
    logic [LEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [OFF_W-1:0] quotient;
    logic [LEN_W-1:0] remainder;
  } div_rsp_t;

endpackage

[rtl/core/pjb_div.sv]
// shared restoring divider: 64-bit dividend by 16-bit divisor, one quotient bit a cycle
// depends on pjb_pkg

module pjb_div (
  input  logic             clk,
  input  logic             rst,
  input  pjb_pkg::div_req_t req,
  output pjb_pkg::div_rsp_t rsp
);

  logic                        busy;
  logic                        done;
  logic [pjb_pkg::DSTEP_W-1:0] step;
  logic [pjb_pkg::OFF_W-1:0]   quo;
  logic [pjb_pkg::LEN_W-1:0]   rem;
  logic [pjb_pkg::LEN_W-1:0]   dvs;
  logic [pjb_pkg::LEN_W:0]     trial;
  logic [pjb_pkg::LEN_W:0]     trial_sub;
  logic                        trial_ge;

  // one restoring step
  assign trial     = {rem, quo[pjb_pkg::OFF_W-1]};
  assign trial_ge  = trial >= {1'b0, dvs};
  assign trial_sub = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
        quo  <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
      end else if (busy) begin
        quo  <= {quo[pjb_pkg::OFF_W-2:0], trial_ge};
        rem  <= trial_ge ? trial_sub[pjb_pkg::LEN_W-1:0] : trial[pjb_pkg::LEN_W-1:0];
        step <= step + 1'b1;
        if (step == pjb_pkg::DSTEP_W'(pjb_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

[rtl/core/packet_jitter_buffer_core.sv]
// packet jitter buffer top level: sequencer, slot memory and output register
// depends on pjb_pkg and pjb_div
//
// channel   dir  signals                         contents
// s_axis    in   tvalid tready tuser tdata[175:0] tuser cmd; tdata session, offset, length, handle
// m_axis    out  tvalid tready tuser tdata[39:0]  tuser status; tdata out_handle, is_playing
// cfg       in   cfg_we cfg_wdata[24:0]           buffer_bytes
//
// from accept to result: a pull reads the slot memory only when playing, a stale offset
// or a lower session needs no division, a first packet one shared-divider pass (buffer
// bytes/length), a later packet two (offset/size, index mod count) or one off the grid
// after reset and after every restart a clearing pass sweeps the whole slot memory
// s_axis is taken only while idle, after the result enters the output register and any
// due clearing pass ends; a finished beat waits in the output register

module packet_jitter_buffer_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic                      s_axis_tuser,   // cmd
  input  logic [175:0]              s_axis_tdata,   // session_number, packet_offset,
                                                    // packet_length, payload_handle
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [2:0]                m_axis_tuser,   // status
  output logic [39:0]               m_axis_tdata,   // out_handle, is_playing, zero fill
  input  logic                      cfg_we,
  input  logic [pjb_pkg::BB_W-1:0]  cfg_wdata
);

  pjb_pkg::state_t state, state_next;

  // latched input beat
  logic                         cmd_q;
  logic [pjb_pkg::SESS_W-1:0]   sess_q;
  logic [pjb_pkg::OFF_W-1:0]    off_q;
  logic [pjb_pkg::LEN_W-1:0]    len_q;
  logic [pjb_pkg::HND_W-1:0]    hnd_q;

  // session state
  logic [pjb_pkg::BB_W-1:0]     buffer_bytes;
  logic                         started;
  logic                         playing;
  logic [pjb_pkg::SESS_W-1:0]   cur_sess;
  logic [pjb_pkg::OFF_W-1:0]    base_off;
  logic [pjb_pkg::LEN_W-1:0]    pkt_size;
  logic [pjb_pkg::CNT_W-1:0]    slot_count;
  logic [pjb_pkg::SLOT_W-1:0]   read_slot;
  logic [pjb_pkg::OFF_W-1:0]    read_pos;
  logic [pjb_pkg::THR_W-1:0]    thr;

  // work registers
  logic [pjb_pkg::OFF_W-1:0]    idx_q;
  logic                         thr_hit;
  logic                         need_clear;
  logic [pjb_pkg::SLOT_W-1:0]   clr_addr;
  pjb_pkg::status_t             res_status;
  logic [pjb_pkg::HND_W-1:0]    res_handle;

  // output register
  pjb_pkg::status_t             out_status;
  logic [pjb_pkg::HND_W-1:0]    out_handle;
  logic                         out_playing;

  // slot memory: full flag over handle
  logic [pjb_pkg::HND_W:0]      slot_mem [pjb_pkg::DEPTH];
  logic [pjb_pkg::HND_W:0]      rd_data;
  logic                         mem_we;
  logic [pjb_pkg::SLOT_W-1:0]   mem_waddr;
  logic [pjb_pkg::HND_W:0]      mem_wdata;

  pjb_pkg::div_req_t            div_req;
  pjb_pkg::div_rsp_t            div_rsp;

  logic                         accept;
  logic                         out_free;
  logic [pjb_pkg::OFF_W-1:0]    diff_c;
  logic                         thr_hit_c;
  logic                         lower_c;
  logic                         ovf_c;
  logic [pjb_pkg::THR_W-1:0]    prod_c;
  logic [pjb_pkg::CNT_W-1:0]    cnt_c;
  logic [pjb_pkg::CNT_W-1:0]    slot_inc;

  pjb_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign s_axis_tready = (state == pjb_pkg::S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // packet arithmetic
  assign diff_c    = off_q - base_off;
  assign thr_hit_c = !playing && (off_q >= base_off) &&
                     (diff_c >= pjb_pkg::OFF_W'(thr));
  assign lower_c   = sess_q < cur_sess;
  assign ovf_c     = (idx_q >= read_pos) &&
                     ((idx_q - read_pos) >= pjb_pkg::OFF_W'(slot_count));
  assign prod_c    = pjb_pkg::THR_W'(pkt_size) * pjb_pkg::THR_W'(slot_count);
  assign slot_inc  = {1'b0, read_slot} + 1'b1;

  // slot count from the first packet, clamped to between 1 and the memory depth
  always_comb begin
    if (div_rsp.quotient > pjb_pkg::OFF_W'(pjb_pkg::DEPTH)) begin
      cnt_c = pjb_pkg::CNT_W'(pjb_pkg::DEPTH);
    end else if (div_rsp.quotient == '0) begin
      cnt_c = pjb_pkg::CNT_W'(1);
    end else begin
      cnt_c = div_rsp.quotient[pjb_pkg::CNT_W-1:0];
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pjb_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state, memory write and divider launch
  always_comb begin
    state_next       = state;
    mem_we           = 1'b0;
    mem_waddr        = '0;
    mem_wdata        = '0;
    div_req.start    = 1'b0;
    div_req.dividend = pjb_pkg::OFF_W'(diff_c);
    div_req.divisor  = pkt_size;
    unique case (state)
      pjb_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        if (clr_addr == pjb_pkg::SLOT_W'(pjb_pkg::DEPTH - 1)) begin
          state_next = pjb_pkg::S_IDLE;
        end
      end
      pjb_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = pjb_pkg::S_DECODE;
        end
      end
      pjb_pkg::S_DECODE: begin
        if (cmd_q == pjb_pkg::CMD_PULL) begin
          state_next = (started && playing) ? pjb_pkg::S_PRD : pjb_pkg::S_RESP;
        end else if (!started) begin
          if (len_q == '0) begin
            state_next = pjb_pkg::S_RESP;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = pjb_pkg::OFF_W'(buffer_bytes);
            div_req.divisor  = len_q;
            state_next       = pjb_pkg::S_FDIV;
          end
        end else if (lower_c || off_q <= base_off) begin
          state_next = pjb_pkg::S_RESP;
        end else begin
          div_req.start = 1'b1;
          state_next    = pjb_pkg::S_QDIV;
        end
      end
      pjb_pkg::S_FDIV: begin
        if (div_rsp.done) begin
          mem_we     = 1'b1;
          mem_wdata  = {1'b1, hnd_q};
          state_next = pjb_pkg::S_FTHR;
        end
      end
      pjb_pkg::S_FTHR: begin
        state_next = pjb_pkg::S_RESP;
      end
      pjb_pkg::S_QDIV: begin
        if (div_rsp.done) begin
          if (div_rsp.remainder != '0) begin
            state_next = pjb_pkg::S_RESP;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = div_rsp.quotient;
            div_req.divisor  = pjb_pkg::LEN_W'(slot_count);
            state_next       = pjb_pkg::S_MDIV;
          end
        end
      end
      pjb_pkg::S_MDIV: begin
        if (div_rsp.done) begin
          state_next = pjb_pkg::S_CHECK;
        end
      end
      pjb_pkg::S_CHECK: begin
        if (!ovf_c) begin
          mem_we    = 1'b1;
          mem_waddr = div_rsp.remainder[pjb_pkg::SLOT_W-1:0];
          mem_wdata = {1'b1, hnd_q};
        end
        state_next = pjb_pkg::S_RESP;
      end
      pjb_pkg::S_PRD: begin
        state_next = pjb_pkg::S_PCHK;
      end
      pjb_pkg::S_PCHK: begin
        if (rd_data[pjb_pkg::HND_W]) begin
          mem_we    = 1'b1;
          mem_waddr = read_slot;
        end
        state_next = pjb_pkg::S_RESP;
      end
      pjb_pkg::S_RESP: begin
        if (out_free) begin
          state_next = need_clear ? pjb_pkg::S_CLEAR : pjb_pkg::S_IDLE;
        end
      end
      default: state_next = pjb_pkg::S_IDLE;
    endcase
  end

  // slot memory, registered read at the play slot
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= slot_mem[read_slot];
  end

  // input capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= s_axis_tuser;
      sess_q <= s_axis_tdata[63:0];
      off_q  <= s_axis_tdata[127:64];
      len_q  <= s_axis_tdata[143:128];
      hnd_q  <= s_axis_tdata[175:144];
    end
  end

  // session state, result and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_bytes  <= pjb_pkg::BB_RESET;
      started       <= 1'b0;
      playing       <= 1'b0;
      cur_sess      <= '0;
      base_off      <= '0;
      pkt_size      <= '0;
      slot_count    <= '0;
      read_slot     <= '0;
      read_pos      <= '0;
      thr           <= '0;
      need_clear    <= 1'b1;
      clr_addr      <= '0;
      m_axis_tvalid <= 1'b0;
      res_status    <= pjb_pkg::ST_NONE;
      res_handle    <= '0;
    end else begin
      if (cfg_we) begin
        buffer_bytes <= cfg_wdata;
      end
      if (state == pjb_pkg::S_RESP && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        pjb_pkg::S_CLEAR: begin
          // address wraps back to zero after the last slot
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == pjb_pkg::SLOT_W'(pjb_pkg::DEPTH - 1)) begin
            need_clear <= 1'b0;
          end
        end
        pjb_pkg::S_DECODE: begin
          thr_hit    <= thr_hit_c;
          res_handle <= '0;
          if (cmd_q == pjb_pkg::CMD_PULL) begin
            res_status <= pjb_pkg::ST_NONE;
          end else if (!started) begin
            res_status <= (len_q == '0) ? pjb_pkg::ST_IGNORED : pjb_pkg::ST_FIRST;
          end else if (lower_c) begin
            // lower session: drop everything and sweep the slots
            started    <= 1'b0;
            playing    <= 1'b0;
            cur_sess   <= '0;
            base_off   <= '0;
            pkt_size   <= '0;
            slot_count <= '0;
            read_slot  <= '0;
            read_pos   <= '0;
            thr        <= '0;
            need_clear <= 1'b1;
            res_status <= pjb_pkg::ST_RESTART;
          end else if (off_q <= base_off) begin
            res_status <= pjb_pkg::ST_IGNORED;
            playing    <= playing | thr_hit_c;
          end
        end
        pjb_pkg::S_FDIV: begin
          if (div_rsp.done) begin
            started    <= 1'b1;
            playing    <= 1'b0;
            cur_sess   <= sess_q;
            base_off   <= off_q;
            pkt_size   <= len_q;
            slot_count <= cnt_c;
            read_slot  <= (cnt_c == pjb_pkg::CNT_W'(1)) ? '0 : pjb_pkg::SLOT_W'(1);
            read_pos   <= pjb_pkg::OFF_W'(1);
          end
        end
        pjb_pkg::S_FTHR: begin
          // threshold at three quarters of the buffer
          thr <= (prod_c + {prod_c[pjb_pkg::THR_W-2:0], 1'b0}) >> 2;
        end
        pjb_pkg::S_QDIV: begin
          if (div_rsp.done) begin
            idx_q <= div_rsp.quotient;
            if (div_rsp.remainder != '0) begin
              res_status <= pjb_pkg::ST_IGNORED;
              playing    <= playing | thr_hit;
            end
          end
        end
        pjb_pkg::S_CHECK: begin
          if (ovf_c) begin
            // index beyond the window: restart
            started    <= 1'b0;
            playing    <= 1'b0;
            cur_sess   <= '0;
            base_off   <= '0;
            pkt_size   <= '0;
            slot_count <= '0;
            read_slot  <= '0;
            read_pos   <= '0;
            thr        <= '0;
            need_clear <= 1'b1;
            res_status <= pjb_pkg::ST_RESTART;
          end else begin
            res_status <= pjb_pkg::ST_STORED;
            playing    <= playing | thr_hit;
          end
        end
        pjb_pkg::S_PCHK: begin
          if (rd_data[pjb_pkg::HND_W]) begin
            res_status <= pjb_pkg::ST_PLAYED;
            res_handle <= rd_data[pjb_pkg::HND_W-1:0];
            read_slot  <= (slot_inc == slot_count) ? '0 : slot_inc[pjb_pkg::SLOT_W-1:0];
            read_pos   <= read_pos + 1'b1;
          end
        end
        pjb_pkg::S_RESP: begin
          if (out_free) begin
            out_status    <= res_status;
            out_handle    <= res_handle;
            out_playing   <= playing;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {7'd0, out_playing, out_handle};

  // checks
  a_restart_not_playing: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == pjb_pkg::ST_RESTART |-> !m_axis_tdata[32])
    else $error("restart beat reports playing");

  a_handle_only_played: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != pjb_pkg::ST_PLAYED |-> m_axis_tdata[31:0] == '0)
    else $error("handle given without play");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    started |-> slot_count != '0 && slot_count <= pjb_pkg::CNT_W'(pjb_pkg::DEPTH))
    else $error("slot count out of range");

  a_read_slot_range: assert property (@(posedge clk) disable iff (rst)
    started |-> {1'b0, read_slot} < slot_count)
    else $error("read slot beyond slot count");

endmodule
